// ===== sv/qvr_pkg.sv =====
// Shared constants and width helpers for the quaternion vector rotation pipeline.
package qvr_pkg;

  localparam int unsigned DEF_DATA_WIDTH = 16;
  localparam int unsigned DEF_FRAC_BITS  = 14;

  // Each half of the rotation is a set of twelve products.
  localparam int unsigned NUM_PROD = 12;

  // Width of the first sums (q * v), wide enough to be exact and to hold the
  // rounding shift, but never above the 64-bit arithmetic of the algorithm.
  function automatic int unsigned sum1_width(int unsigned dw, int unsigned fb);
    int unsigned w;
    w = 2 * dw + 3;
    if (fb + 2 > w) w = fb + 2;
    if (w > 64) w = 64;
    return w;
  endfunction

  // Width of the second sums (t * conj(q)).
  function automatic int unsigned sum2_width(int unsigned dw, int unsigned fb);
    int unsigned w;
    w = sum1_width(dw, fb) - fb + dw + 3;
    if (fb + 2 > w) w = fb + 2;
    if (w > 64) w = 64;
    return w;
  endfunction

endpackage

// ===== sv/qvr_in_if.sv =====
// Input channel: quaternion and vector with a valid/ready handshake.
interface qvr_in_if #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DEF_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );

  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

// ===== sv/qvr_out_if.sv =====
// Output channel: rotated vector and saturation flag with a valid/ready handshake.
interface qvr_out_if #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DEF_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rot_x;
  logic signed [DATA_WIDTH-1:0] rot_y;
  logic signed [DATA_WIDTH-1:0] rot_z;
  logic                         saturated;

  modport source (
    output valid, rot_x, rot_y, rot_z, saturated,
    input  ready
  );

  modport sink (
    input  valid, rot_x, rot_y, rot_z, saturated,
    output ready
  );
endinterface

// ===== sv/quaternion_vector_rotation.sv =====
// Quaternion vector rotation: v' = q * (0,v) * conj(q) in a four-stage pipeline.
//
// The input channel in_i carries a quaternion (quat_w..quat_z, FRAC_BITS
// fraction bits) and a vector (vec_x..vec_z); the output channel out_o carries
// the rotated vector (rot_x..rot_z, same format as the input vector) and a
// saturated flag that is set when any component was clipped. Both channels
// use valid/ready; a transaction completes when both are high at a clock edge.
// The quaternion is not normalized, so a non-unit q also scales the vector by
// its squared norm. Each Q rescale rounds to nearest with ties toward plus
// infinity.
// The input transaction loads the first stage; the item then passes through the
// four register stages in order (q*v products, t sums, t*conj(q) products, sums
// with saturation), and out_o.valid rises once it reaches the last one. One item
// is accepted every cycle while out_o does not stall.
// Every stage holds its contents while the one after it is full and not
// draining, so a stall on out_o backs up into in_i.ready without loss; empty
// stages still fill while the output waits. Reset empties all stages.
module quaternion_vector_rotation #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DEF_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = qvr_pkg::DEF_FRAC_BITS
) (
  input logic        clk_i,
  input logic        rst_ni,
  qvr_in_if.sink     in_i,
  qvr_out_if.source  out_o
);
  import qvr_pkg::*;

  localparam int unsigned T_WIDTH = sum1_width(DATA_WIDTH, FRAC_BITS) - FRAC_BITS;

  logic en1, en2, en3, en4;
  logic valid1, valid2, valid3, valid4;

  logic signed [DATA_WIDTH-1:0]         q1_w, q1_x, q1_y, q1_z;
  logic signed [DATA_WIDTH-1:0]         q2_w, q2_x, q2_y, q2_z;
  logic signed [2*DATA_WIDTH-1:0]       prod1 [NUM_PROD];
  logic signed [T_WIDTH-1:0]            t_w, t_x, t_y, t_z;
  logic signed [T_WIDTH+DATA_WIDTH-1:0] prod2 [NUM_PROD];

  // A stage may load when it is empty or when the stage after it loads.
  assign en4 = !valid4 || out_o.ready;
  assign en3 = !valid3 || en4;
  assign en2 = !valid2 || en3;
  assign en1 = !valid1 || en2;

  assign in_i.ready  = en1;
  assign out_o.valid = valid4;

  qvr_mul1 #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en1),
    .valid_i  (in_i.valid),
    .quat_w_i (in_i.quat_w),
    .quat_x_i (in_i.quat_x),
    .quat_y_i (in_i.quat_y),
    .quat_z_i (in_i.quat_z),
    .vec_x_i  (in_i.vec_x),
    .vec_y_i  (in_i.vec_y),
    .vec_z_i  (in_i.vec_z),
    .valid_o  (valid1),
    .quat_w_o (q1_w),
    .quat_x_o (q1_x),
    .quat_y_o (q1_y),
    .quat_z_o (q1_z),
    .prod_o   (prod1)
  );

  qvr_sum1 #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .T_WIDTH    (T_WIDTH)
  ) u_sum1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en2),
    .valid_i  (valid1),
    .quat_w_i (q1_w),
    .quat_x_i (q1_x),
    .quat_y_i (q1_y),
    .quat_z_i (q1_z),
    .prod_i   (prod1),
    .valid_o  (valid2),
    .quat_w_o (q2_w),
    .quat_x_o (q2_x),
    .quat_y_o (q2_y),
    .quat_z_o (q2_z),
    .t_w_o    (t_w),
    .t_x_o    (t_x),
    .t_y_o    (t_y),
    .t_z_o    (t_z)
  );

  qvr_mul2 #(
    .DATA_WIDTH (DATA_WIDTH),
    .T_WIDTH    (T_WIDTH)
  ) u_mul2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en3),
    .valid_i  (valid2),
    .quat_w_i (q2_w),
    .quat_x_i (q2_x),
    .quat_y_i (q2_y),
    .quat_z_i (q2_z),
    .t_w_i    (t_w),
    .t_x_i    (t_x),
    .t_y_i    (t_y),
    .t_z_i    (t_z),
    .valid_o  (valid3),
    .prod_o   (prod2)
  );

  qvr_sum2 #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .T_WIDTH    (T_WIDTH)
  ) u_sum2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en4),
    .valid_i     (valid3),
    .prod_i      (prod2),
    .valid_o     (valid4),
    .rot_x_o     (out_o.rot_x),
    .rot_y_o     (out_o.rot_y),
    .rot_z_o     (out_o.rot_z),
    .saturated_o (out_o.saturated)
  );

endmodule

// ===== sv/qvr_mul1.sv =====
// First multiply stage: the twelve products of q and v, registered.
module qvr_mul1 #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DEF_DATA_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [DATA_WIDTH-1:0]   quat_w_i,
  input  logic signed [DATA_WIDTH-1:0]   quat_x_i,
  input  logic signed [DATA_WIDTH-1:0]   quat_y_i,
  input  logic signed [DATA_WIDTH-1:0]   quat_z_i,
  input  logic signed [DATA_WIDTH-1:0]   vec_x_i,
  input  logic signed [DATA_WIDTH-1:0]   vec_y_i,
  input  logic signed [DATA_WIDTH-1:0]   vec_z_i,
  output logic                           valid_o,
  output logic signed [DATA_WIDTH-1:0]   quat_w_o,
  output logic signed [DATA_WIDTH-1:0]   quat_x_o,
  output logic signed [DATA_WIDTH-1:0]   quat_y_o,
  output logic signed [DATA_WIDTH-1:0]   quat_z_o,
  output logic signed [2*DATA_WIDTH-1:0] prod_o [qvr_pkg::NUM_PROD]
);
  import qvr_pkg::*;

  logic                           valid_q;
  logic signed [DATA_WIDTH-1:0]   quat_w_q, quat_x_q, quat_y_q, quat_z_q;
  logic signed [2*DATA_WIDTH-1:0] prod_d [NUM_PROD];
  logic signed [2*DATA_WIDTH-1:0] prod_q [NUM_PROD];

  // Products grouped by the component of t they feed: w, x, y, z.
  always_comb begin
    prod_d[0]  = quat_x_i * vec_x_i;
    prod_d[1]  = quat_y_i * vec_y_i;
    prod_d[2]  = quat_z_i * vec_z_i;
    prod_d[3]  = quat_w_i * vec_x_i;
    prod_d[4]  = quat_y_i * vec_z_i;
    prod_d[5]  = quat_z_i * vec_y_i;
    prod_d[6]  = quat_w_i * vec_y_i;
    prod_d[7]  = quat_x_i * vec_z_i;
    prod_d[8]  = quat_z_i * vec_x_i;
    prod_d[9]  = quat_w_i * vec_z_i;
    prod_d[10] = quat_x_i * vec_y_i;
    prod_d[11] = quat_y_i * vec_x_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      quat_w_q <= quat_w_i;
      quat_x_q <= quat_x_i;
      quat_y_q <= quat_y_i;
      quat_z_q <= quat_z_i;
      prod_q   <= prod_d;
    end
  end

  assign valid_o  = valid_q;
  assign quat_w_o = quat_w_q;
  assign quat_x_o = quat_x_q;
  assign quat_y_o = quat_y_q;
  assign quat_z_o = quat_z_q;
  assign prod_o   = prod_q;

endmodule

// ===== sv/qvr_sum1.sv =====
// First sum stage: adds the q*v products into t and rounds it back by the fraction bits.
module qvr_sum1 #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DEF_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = qvr_pkg::DEF_FRAC_BITS,
  parameter int unsigned T_WIDTH    = qvr_pkg::sum1_width(DATA_WIDTH, FRAC_BITS) - FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [DATA_WIDTH-1:0]   quat_w_i,
  input  logic signed [DATA_WIDTH-1:0]   quat_x_i,
  input  logic signed [DATA_WIDTH-1:0]   quat_y_i,
  input  logic signed [DATA_WIDTH-1:0]   quat_z_i,
  input  logic signed [2*DATA_WIDTH-1:0] prod_i [qvr_pkg::NUM_PROD],
  output logic                           valid_o,
  output logic signed [DATA_WIDTH-1:0]   quat_w_o,
  output logic signed [DATA_WIDTH-1:0]   quat_x_o,
  output logic signed [DATA_WIDTH-1:0]   quat_y_o,
  output logic signed [DATA_WIDTH-1:0]   quat_z_o,
  output logic signed [T_WIDTH-1:0]      t_w_o,
  output logic signed [T_WIDTH-1:0]      t_x_o,
  output logic signed [T_WIDTH-1:0]      t_y_o,
  output logic signed [T_WIDTH-1:0]      t_z_o
);
  import qvr_pkg::*;

  localparam int unsigned S_WIDTH = sum1_width(DATA_WIDTH, FRAC_BITS);
  localparam logic [S_WIDTH-1:0] HALF = {{(S_WIDTH-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic                         valid_q;
  logic signed [DATA_WIDTH-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
  logic signed [S_WIDTH-1:0]    ext [NUM_PROD];
  logic        [S_WIDTH-1:0]    sum_w, sum_x, sum_y, sum_z;
  logic signed [T_WIDTH-1:0]    t_w_d, t_x_d, t_y_d, t_z_d;
  logic signed [T_WIDTH-1:0]    t_w_q, t_x_q, t_y_q, t_z_q;

  always_comb begin
    for (int i = 0; i < NUM_PROD; i++) begin
      ext[i] = S_WIDTH'(prod_i[i]);
    end
  end

  // Rounding adds one half LSB of the result, so ties go toward plus infinity.
  always_comb begin
    sum_w = HALF - ext[0] - ext[1] - ext[2];
    sum_x = HALF + ext[3] + ext[4] - ext[5];
    sum_y = HALF + ext[6] - ext[7] + ext[8];
    sum_z = HALF + ext[9] + ext[10] - ext[11];
    t_w_d = sum_w[S_WIDTH-1:FRAC_BITS];
    t_x_d = sum_x[S_WIDTH-1:FRAC_BITS];
    t_y_d = sum_y[S_WIDTH-1:FRAC_BITS];
    t_z_d = sum_z[S_WIDTH-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      quat_w_q <= quat_w_i;
      quat_x_q <= quat_x_i;
      quat_y_q <= quat_y_i;
      quat_z_q <= quat_z_i;
      t_w_q    <= t_w_d;
      t_x_q    <= t_x_d;
      t_y_q    <= t_y_d;
      t_z_q    <= t_z_d;
    end
  end

  assign valid_o  = valid_q;
  assign quat_w_o = quat_w_q;
  assign quat_x_o = quat_x_q;
  assign quat_y_o = quat_y_q;
  assign quat_z_o = quat_z_q;
  assign t_w_o    = t_w_q;
  assign t_x_o    = t_x_q;
  assign t_y_o    = t_y_q;
  assign t_z_o    = t_z_q;

endmodule

// ===== sv/qvr_mul2.sv =====
// Second multiply stage: the twelve products of t and q, registered.
module qvr_mul2 #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DEF_DATA_WIDTH,
  parameter int unsigned T_WIDTH    = qvr_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [DATA_WIDTH-1:0]        quat_w_i,
  input  logic signed [DATA_WIDTH-1:0]        quat_x_i,
  input  logic signed [DATA_WIDTH-1:0]        quat_y_i,
  input  logic signed [DATA_WIDTH-1:0]        quat_z_i,
  input  logic signed [T_WIDTH-1:0]           t_w_i,
  input  logic signed [T_WIDTH-1:0]           t_x_i,
  input  logic signed [T_WIDTH-1:0]           t_y_i,
  input  logic signed [T_WIDTH-1:0]           t_z_i,
  output logic                                valid_o,
  output logic signed [T_WIDTH+DATA_WIDTH-1:0] prod_o [qvr_pkg::NUM_PROD]
);
  import qvr_pkg::*;

  localparam int unsigned P_WIDTH = T_WIDTH + DATA_WIDTH;

  logic                      valid_q;
  logic signed [P_WIDTH-1:0] prod_d [NUM_PROD];
  logic signed [P_WIDTH-1:0] prod_q [NUM_PROD];

  // Products grouped by the component of r they feed: x, y, z.
  always_comb begin
    prod_d[0]  = t_x_i * quat_w_i;
    prod_d[1]  = t_w_i * quat_x_i;
    prod_d[2]  = t_y_i * quat_z_i;
    prod_d[3]  = t_z_i * quat_y_i;
    prod_d[4]  = t_y_i * quat_w_i;
    prod_d[5]  = t_w_i * quat_y_i;
    prod_d[6]  = t_x_i * quat_z_i;
    prod_d[7]  = t_z_i * quat_x_i;
    prod_d[8]  = t_z_i * quat_w_i;
    prod_d[9]  = t_w_i * quat_z_i;
    prod_d[10] = t_x_i * quat_y_i;
    prod_d[11] = t_y_i * quat_x_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

// ===== sv/qvr_sum2.sv =====
// Second sum stage: adds the t*conj(q) products, rounds, saturates and holds the result.
module qvr_sum2 #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DEF_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = qvr_pkg::DEF_FRAC_BITS,
  parameter int unsigned T_WIDTH    = qvr_pkg::sum1_width(DATA_WIDTH, FRAC_BITS) - FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [T_WIDTH+DATA_WIDTH-1:0] prod_i [qvr_pkg::NUM_PROD],
  output logic                                 valid_o,
  output logic signed [DATA_WIDTH-1:0]         rot_x_o,
  output logic signed [DATA_WIDTH-1:0]         rot_y_o,
  output logic signed [DATA_WIDTH-1:0]         rot_z_o,
  output logic                                 saturated_o
);
  import qvr_pkg::*;

  localparam int unsigned P_WIDTH = T_WIDTH + DATA_WIDTH;
  localparam int unsigned S_WIDTH = sum2_width(DATA_WIDTH, FRAC_BITS);
  localparam int unsigned E_WIDTH = (P_WIDTH > S_WIDTH) ? P_WIDTH : S_WIDTH;
  localparam int unsigned R_WIDTH = S_WIDTH - FRAC_BITS;
  localparam int unsigned C_WIDTH = (R_WIDTH > DATA_WIDTH) ? R_WIDTH : DATA_WIDTH;
  localparam logic [S_WIDTH-1:0] HALF = {{(S_WIDTH-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [C_WIDTH-1:0] SAT_HI =
    {{(C_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [C_WIDTH-1:0] SAT_LO = ~SAT_HI;

  logic                         valid_q;
  logic signed [E_WIDTH-1:0]    wide [NUM_PROD];
  logic        [S_WIDTH-1:0]    ext  [NUM_PROD];
  logic        [S_WIDTH-1:0]    sum  [3];
  logic signed [R_WIDTH-1:0]    rnd  [3];
  logic signed [C_WIDTH-1:0]    cmp  [3];
  logic signed [DATA_WIDTH-1:0] rot_d [3];
  logic        [2:0]            clip;
  logic signed [DATA_WIDTH-1:0] rot_x_q, rot_y_q, rot_z_q;
  logic                         saturated_q;

  // Products wider than the sum are taken modulo its width, as the sums wrap there.
  always_comb begin
    for (int i = 0; i < NUM_PROD; i++) begin
      wide[i] = E_WIDTH'(prod_i[i]);
      ext[i]  = wide[i][S_WIDTH-1:0];
    end
  end

  always_comb begin
    sum[0] = HALF + ext[0] - ext[1]  - ext[2]  + ext[3];
    sum[1] = HALF + ext[4] - ext[5]  + ext[6]  - ext[7];
    sum[2] = HALF + ext[8] - ext[9]  - ext[10] + ext[11];
    for (int k = 0; k < 3; k++) begin
      rnd[k] = sum[k][S_WIDTH-1:FRAC_BITS];
      cmp[k] = C_WIDTH'(rnd[k]);
      if (cmp[k] > SAT_HI) begin
        rot_d[k] = SAT_HI[DATA_WIDTH-1:0];
        clip[k]  = 1'b1;
      end else if (cmp[k] < SAT_LO) begin
        rot_d[k] = SAT_LO[DATA_WIDTH-1:0];
        clip[k]  = 1'b1;
      end else begin
        rot_d[k] = cmp[k][DATA_WIDTH-1:0];
        clip[k]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      rot_x_q     <= rot_d[0];
      rot_y_q     <= rot_d[1];
      rot_z_q     <= rot_d[2];
      saturated_q <= |clip;
    end
  end

  assign valid_o     = valid_q;
  assign rot_x_o     = rot_x_q;
  assign rot_y_o     = rot_y_q;
  assign rot_z_o     = rot_z_q;
  assign saturated_o = saturated_q;

endmodule

// ===== tb/quaternion_vector_rotation_test.sv =====
// Self-checking testbench for the quaternion vector rotation pipeline.
module quaternion_vector_rotation_test;
  import qvr_pkg::*;

  localparam int unsigned DW = DEF_DATA_WIDTH;
  localparam int unsigned FB = DEF_FRAC_BITS;
  localparam longint ROT_MAX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint ROT_MIN = -ROT_MAX - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic signed [DW-1:0] w;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] vz;
  } rotation_req_t;

  typedef struct packed {
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] rz;
    logic                 sat;
  } rotated_vec_t;

  logic clk;
  logic rst_n;

  qvr_in_if  #(.DATA_WIDTH(DW)) rot_in ();
  qvr_out_if #(.DATA_WIDTH(DW)) rot_out ();

  quaternion_vector_rotation #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (rot_in),
    .out_o (rot_out)
  );

  rotated_vec_t pending_rotations[$];
  int mismatch_count;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;
  int stall_len;
  logic stall_toggle;
  logic stall_seen;
  int hold_left;

  always #6 clk = ~clk;

  // Round to nearest with ties toward plus infinity, then drop the fraction bits.
  function automatic longint round_q(longint v);
    return (v + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic logic signed [DW-1:0] clip_component(longint v, inout logic flag);
    if (v > ROT_MAX) begin
      flag = 1'b1;
      return DW'(ROT_MAX);
    end
    if (v < ROT_MIN) begin
      flag = 1'b1;
      return DW'(ROT_MIN);
    end
    return DW'(v);
  endfunction

  // Computes q * (0,v) * conj(q) with one rescale per half, as the sum stages do.
  function automatic rotated_vec_t rotate_vector(rotation_req_t r);
    longint w, x, y, z, vx, vy, vz;
    longint tw, tx, ty, tz;
    rotated_vec_t res;
    logic flag;
    w  = $signed(r.w);
    x  = $signed(r.x);
    y  = $signed(r.y);
    z  = $signed(r.z);
    vx = $signed(r.vx);
    vy = $signed(r.vy);
    vz = $signed(r.vz);
    tw = round_q(-x * vx - y * vy - z * vz);
    tx = round_q(w * vx + y * vz - z * vy);
    ty = round_q(w * vy - x * vz + z * vx);
    tz = round_q(w * vz + x * vy - y * vx);
    flag = 1'b0;
    res.rx = clip_component(round_q(tx * w - tw * x - ty * z + tz * y), flag);
    res.ry = clip_component(round_q(ty * w - tw * y + tx * z - tz * x), flag);
    res.rz = clip_component(round_q(tz * w - tw * z - tx * y + ty * x), flag);
    res.sat = flag;
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatch_count < 10)
        $display("mismatch on %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
      mismatch_count++;
    end
  endfunction

  // Result checker: every output transaction is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    rotated_vec_t want;
    if (rst_n && rot_out.valid && rot_out.ready) begin
      if (pending_rotations.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result (%0d,%0d,%0d) at %0t",
                   rot_out.rot_x, rot_out.rot_y, rot_out.rot_z, $realtime);
        mismatch_count++;
      end else begin
        want = pending_rotations.pop_front();
        check_field("rot_x", want.rx, rot_out.rot_x);
        check_field("rot_y", want.ry, rot_out.rot_y);
        check_field("rot_z", want.rz, rot_out.rot_z);
        check_field("saturated", want.sat, rot_out.saturated);
      end
    end
  end

  // Output ready: random idling, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (stall_toggle != stall_seen) begin
      stall_seen = stall_toggle;
      hold_left = stall_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      rot_out.ready <= 1'b0;
    end else begin
      rot_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((rot_in.valid && rot_in.ready) || (rot_out.valid && rot_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called and returns at a falling edge.
  task automatic send_rotation(rotation_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      rot_in.valid <= 1'b0;
      @(negedge clk);
    end
    rot_in.valid  <= 1'b1;
    rot_in.quat_w <= item.w;
    rot_in.quat_x <= item.x;
    rot_in.quat_y <= item.y;
    rot_in.quat_z <= item.z;
    rot_in.vec_x  <= item.vx;
    rot_in.vec_y  <= item.vy;
    rot_in.vec_z  <= item.vz;
    @(posedge clk);
    while (!rot_in.ready) @(posedge clk);
    pending_rotations.push_back(rotate_vector(item));
    @(negedge clk);
  endtask

  task automatic send_fields(int w, int x, int y, int z, int vx, int vy, int vz);
    rotation_req_t item;
    item = '{w: DW'(w), x: DW'(x), y: DW'(y), z: DW'(z),
             vx: DW'(vx), vy: DW'(vy), vz: DW'(vz)};
    send_rotation(item);
  endtask

  task automatic wait_for_drain();
    rot_in.valid <= 1'b0;
    while (pending_rotations.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DW-1:0] pick_extreme();
    case ($urandom_range(5))
      0: return DW'(ROT_MIN);
      1: return DW'(-1);
      2: return DW'(0);
      3: return DW'(1);
      4: return DW'(1 << FB);
      default: return DW'(ROT_MAX);
    endcase
  endfunction

  function automatic rotation_req_t random_rotation();
    rotation_req_t item;
    item = rotation_req_t'({$urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        // Components within a half keep the squared norm at or below one.
        item.w = DW'($urandom_range(1 << FB) - (1 << (FB - 1)));
        item.x = DW'($urandom_range(1 << FB) - (1 << (FB - 1)));
        item.y = DW'($urandom_range(1 << FB) - (1 << (FB - 1)));
        item.z = DW'($urandom_range(1 << FB) - (1 << (FB - 1)));
      end
      5, 6: ;
      7: begin
        item = '{w: pick_extreme(), x: pick_extreme(), y: pick_extreme(),
                 z: pick_extreme(), vx: pick_extreme(), vy: pick_extreme(),
                 vz: pick_extreme()};
      end
      default: begin
        item.w = DW'($urandom_range(4096) - 2048);
        item.x = DW'($urandom_range(4096) - 2048);
        item.y = DW'($urandom_range(4096) - 2048);
        item.z = DW'($urandom_range(4096) - 2048);
      end
    endcase
    return item;
  endfunction

  task automatic test_directed_cases();
    send_fields(16384, 0, 0, 0, 32767, -32768, 1);
    send_fields(16384, 0, 0, 0, -1, 0, -32768);
    send_fields(16384, 0, 0, 0, -32768, -32768, -32768);
    send_fields(0, 0, 0, 0, 32767, 32767, 32767);
    // Half-scale quaternion: products land exactly on rounding ties.
    send_fields(8192, 0, 0, 0, 1, -1, 3);
    send_fields(8192, 0, 0, 0, -3, 5, -5);
    send_fields(11585, 0, 0, 11585, 10000, 0, 0);
    send_fields(11585, 11585, 0, 0, 0, 10000, -5000);
    send_fields(11585, 0, 11585, 0, 1234, -4321, 999);
    send_fields(0, 16384, 0, 0, 100, 200, 300);
    send_fields(4096, 4096, 4096, 4096, 1000, 2000, 3000);
    send_fields(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_fields(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    // A quaternion of norm two scales the vector by four.
    send_fields(-32768, 0, 0, 0, 10000, -10000, 8191);
    send_fields(-32768, -32768, -32768, -32768, -32768, 32767, -32768);
    send_fields(16383, 1, -1, 0, 1, 1, 1);
    send_fields(0, 0, 0, -32768, 32767, 0, -32768);
    send_fields(32767, -32768, 32767, -32768, 0, -1, 0);
    wait_for_drain();
  endtask

  task automatic test_random_phase(int sender_idle, int receiver_idle, int count);
    send_idle_pct = sender_idle;
    recv_idle_pct <= receiver_idle;
    repeat (count) send_rotation(random_rotation());
    wait_for_drain();
  endtask

  // The receiver holds off while items keep coming, so the pipeline fills and
  // input ready drops.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    stall_len <= 300;
    stall_toggle <= ~stall_toggle;
    repeat (40) send_rotation(random_rotation());
    wait_for_drain();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    idle_cycles = 0;
    stall_len = 0;
    stall_toggle = 1'b0;
    stall_seen = 1'b0;
    hold_left = 0;
    rot_in.valid = 1'b0;
    rot_in.quat_w = '0;
    rot_in.quat_x = '0;
    rot_in.quat_y = '0;
    rot_in.quat_z = '0;
    rot_in.vec_x = '0;
    rot_in.vec_y = '0;
    rot_in.vec_z = '0;
    rot_out.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_random_phase(27, 80, 560);
    test_random_phase(80, 27, 560);
    test_output_stall();
    test_random_phase(0, 0, 580);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rotations.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
